### hw/rtl/ptps_pkg.sv
package ptps_pkg;

	localparam int XY_BITS = 10;
	localparam int TIME_BITS = 16;
	localparam int CFG_BITS = 16;
	localparam int DEPTH_BITS = 12;
	localparam int DEPTH_STEPS = 12;
	localparam int ANGLE_BITS = 9;
	localparam int Z_BITS = 21;
	localparam int S_BITS = 27;
	localparam int THIRD_BITS = 15;
	localparam int PRE_SHIFT = 16;

	// squared radius bound: d*d*S <= 2^26
	localparam logic [S_BITS-1:0] S_LIMIT = 27'd67108864;
	localparam logic [S_BITS-1:0] S_SAT = 27'd67108865;
	localparam logic [S_BITS-1:0] S_NEAR = 27'd16;
	localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = 12'd2048;

	localparam logic signed [Z_BITS-1:0] Z_QUARTER = 21'sd262144;
	localparam logic signed [Z_BITS-1:0] Z_EIGHTH = 21'sd131072;
	localparam logic [Z_BITS:0] Z_OFFSET = 22'd1048576;

	// floor(t/3) = (t*43691) >> 17 for any 16-bit t
	localparam logic [16:0] THIRD_MUL = 17'd43691;
	localparam int THIRD_SHIFT = 17;
	// floor(f/5) = (f*205) >> 10 for any 8-bit f
	localparam logic [7:0] FIFTH_MUL = 8'd205;
	localparam int FIFTH_SHIFT = 10;

	typedef enum logic [1:0] {
		REG_WIDTH = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_TIME = 2'd2
	} cfg_reg_t;

	// atan(2^-i) in units of 2^-20 turn
	function automatic logic signed [Z_BITS-1:0] atan_step(input int i);
		logic signed [Z_BITS-1:0] r;
		case (i)
			0: r = 21'sd131072;
			1: r = 21'sd77376;
			2: r = 21'sd40884;
			3: r = 21'sd20753;
			4: r = 21'sd10417;
			5: r = 21'sd5213;
			6: r = 21'sd2607;
			7: r = 21'sd1304;
			8: r = 21'sd652;
			9: r = 21'sd326;
			10: r = 21'sd163;
			11: r = 21'sd81;
			12: r = 21'sd41;
			13: r = 21'sd20;
			14: r = 21'sd10;
			15: r = 21'sd5;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/polar_tunnel_pixel_shader_unit.sv
// throughput: one pixel per cycle while intensity_ready stays high, set by the per-stage depth
// bit search and cordic rotation
// stall: each stage holds only while the stage after it is full and held
// reset: clears the valid bits and loads width 160, height 100, frame time 0
module polar_tunnel_pixel_shader_unit #(
	parameter int COORD_BITS = 10,
	parameter int ANGLE_ITERATIONS = 12
) (
	input logic clk,
	input logic arst_n,
	input logic pixel_valid,
	output logic pixel_ready,
	input logic [ptps_pkg::XY_BITS-1:0] pixel_x,
	input logic [ptps_pkg::XY_BITS-1:0] pixel_y,
	output logic intensity_valid,
	input logic intensity_ready,
	output logic [7:0] intensity,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [ptps_pkg::CFG_BITS-1:0] cfg_data
);
	import ptps_pkg::*;

	localparam int NS = (ANGLE_ITERATIONS > DEPTH_STEPS) ? ANGLE_ITERATIONS : DEPTH_STEPS;
	localparam int NST = NS + 3;
	localparam int AW = COORD_BITS + 22;

	logic [XY_BITS-1:0] width_q, height_q;
	logic [TIME_BITS-1:0] time_q;
	logic [THIRD_BITS-1:0] third_q;
	logic [TIME_BITS+16:0] tprod;

	assign tprod = time_q * THIRD_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 10'd160;
			height_q <= 10'd100;
			time_q <= '0;
			third_q <= '0;
		end else begin
			third_q <= tprod[THIRD_SHIFT+THIRD_BITS-1:THIRD_SHIFT];
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_WIDTH: width_q <= cfg_data[XY_BITS-1:0];
					REG_HEIGHT: height_q <= cfg_data[XY_BITS-1:0];
					REG_TIME: time_q <= cfg_data[TIME_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	// per-stage valid and advance; bubbles are squeezed out under stall
	logic [NST-1:0] v_q;
	logic [NST-1:0] en;

	always_comb begin
		en[NST-1] = !v_q[NST-1] || intensity_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= pixel_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign pixel_ready = en[0];
	assign intensity_valid = v_q[NST-1];

	logic [S_BITS-1:0] s_s2;
	logic signed [AW-1:0] x_s2, y_s2;
	logic signed [Z_BITS-1:0] z_s2;
	logic iter_s2;
	logic [DEPTH_BITS-1:0] depth;
	logic [ANGLE_BITS-1:0] angle;

	ptps_front #(
		.CB(COORD_BITS),
		.AW(AW)
	) u_front (
		.clk(clk),
		.en(en[1:0]),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.width(width_q),
		.height(height_q),
		.s_s2(s_s2),
		.x_s2(x_s2),
		.y_s2(y_s2),
		.z_s2(z_s2),
		.iter_s2(iter_s2)
	);

	ptps_depth #(
		.NS(NS)
	) u_depth (
		.clk(clk),
		.en(en[NS+1:2]),
		.s(s_s2),
		.depth(depth)
	);

	ptps_cordic #(
		.AW(AW),
		.NS(NS),
		.NITER(ANGLE_ITERATIONS)
	) u_cordic (
		.clk(clk),
		.en(en[NS+1:2]),
		.x(x_s2),
		.y(y_s2),
		.z(z_s2),
		.iter(iter_s2),
		.angle(angle)
	);

	ptps_shade u_shade (
		.clk(clk),
		.en(en[NST-1]),
		.depth(depth),
		.angle(angle),
		.t(time_q),
		.t_third(third_q),
		.intensity_s(intensity)
	);

endmodule

### hw/rtl/ptps_front.sv
module ptps_front #(
	parameter int CB = 10,
	parameter int AW = 32
) (
	input logic clk,
	input logic [1:0] en,
	input logic [ptps_pkg::XY_BITS-1:0] pixel_x,
	input logic [ptps_pkg::XY_BITS-1:0] pixel_y,
	input logic [ptps_pkg::XY_BITS-1:0] width,
	input logic [ptps_pkg::XY_BITS-1:0] height,
	output logic [ptps_pkg::S_BITS-1:0] s_s2,
	output logic signed [AW-1:0] x_s2,
	output logic signed [AW-1:0] y_s2,
	output logic signed [ptps_pkg::Z_BITS-1:0] z_s2,
	output logic iter_s2
);
	import ptps_pkg::*;

	localparam int DXW = CB + 2;
	localparam int DYW = CB + 3;
	localparam int SW = 2 * DYW + 1;
	localparam int EW = (SW > S_BITS) ? SW : S_BITS;

	logic [CB-1:0] px, py, w, h;

	generate
		if (CB <= XY_BITS) begin : g_trim
			assign px = pixel_x[CB-1:0];
			assign py = pixel_y[CB-1:0];
			assign w = width[CB-1:0];
			assign h = height[CB-1:0];
		end else begin : g_ext
			assign px = {{(CB-XY_BITS){1'b0}}, pixel_x};
			assign py = {{(CB-XY_BITS){1'b0}}, pixel_y};
			assign w = {{(CB-XY_BITS){1'b0}}, width};
			assign h = {{(CB-XY_BITS){1'b0}}, height};
		end
	endgenerate

	// offsets from the centre: x in half units, y in quarter units
	logic signed [DXW-1:0] dx_s1;
	logic signed [DYW-1:0] dy_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1 <= $signed({1'b0, px, 1'b0}) - $signed({2'b00, w});
			dy_s1 <= $signed({1'b0, py, 2'b00}) - $signed({2'b00, h, 1'b0});
		end
	end

	logic signed [DYW-1:0] xe, ye;
	logic signed [2*DYW-1:0] x2, y2;
	logic [SW-1:0] s_sum;
	logic [EW-1:0] s_ext;
	logic [S_BITS-1:0] s_sat;

	assign xe = DYW'(dx_s1);
	assign ye = dy_s1;
	assign x2 = xe * xe;
	assign y2 = ye * ye;
	assign s_sum = {1'b0, x2} + {1'b0, y2};
	assign s_ext = EW'(s_sum);
	// anything past the bound gives depth 0 anyway
	assign s_sat = (s_ext > EW'(S_LIMIT)) ? S_SAT : s_ext[S_BITS-1:0];

	logic signed [DYW:0] xr, yr;
	logic signed [Z_BITS-1:0] zr;
	logic iter;

	// fold the left half plane by a quarter turn, catch axes and diagonals
	always_comb begin
		xr = (DYW+1)'(xe);
		yr = (DYW+1)'(ye);
		zr = '0;
		iter = 1'b0;
		if (xe < 0) begin
			if (ye >= 0) begin
				xr = (DYW+1)'(ye);
				yr = -((DYW+1)'(xe));
				zr = Z_QUARTER;
			end else begin
				xr = -((DYW+1)'(ye));
				yr = (DYW+1)'(xe);
				zr = -Z_QUARTER;
			end
		end
		if (yr == 0) begin
			iter = 1'b0;
		end else if (xr == 0) begin
			zr = (yr > 0) ? zr + Z_QUARTER : zr - Z_QUARTER;
		end else if (yr == xr) begin
			zr = zr + Z_EIGHTH;
		end else if (yr == -xr) begin
			zr = zr - Z_EIGHTH;
		end else begin
			iter = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			s_s2 <= s_sat;
			x_s2 <= AW'(xr) <<< PRE_SHIFT;
			y_s2 <= AW'(yr) <<< PRE_SHIFT;
			z_s2 <= zr;
			iter_s2 <= iter;
		end
	end

endmodule

### hw/rtl/ptps_depth.sv
module ptps_depth #(
	parameter int NS = 12
) (
	input logic clk,
	input logic [NS-1:0] en,
	input logic [ptps_pkg::S_BITS-1:0] s,
	output logic [ptps_pkg::DEPTH_BITS-1:0] depth
);
	import ptps_pkg::*;

	localparam int TW = S_BITS + 2 * DEPTH_BITS;

	// running d, d*d*S and d*S, one result bit per stage for the first DEPTH_STEPS stages
	logic [DEPTH_BITS-1:0] d_s [NS+1];
	logic [S_BITS-1:0] p_s [NS+1];
	logic [S_BITS-1:0] ds_s [NS+1];
	logic [S_BITS-1:0] s_s [NS+1];
	logic near_s [NS+1];

	assign d_s[0] = '0;
	assign p_s[0] = '0;
	assign ds_s[0] = '0;
	assign s_s[0] = s;
	assign near_s[0] = (s < S_NEAR);

	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_stage
			logic [DEPTH_BITS-1:0] nd;
			logic [S_BITS-1:0] np, nds;
			if (k < DEPTH_STEPS) begin : g_bit
				localparam int B = DEPTH_STEPS - 1 - k;
				logic [TW-1:0] trial, dnext;
				always_comb begin
					// (d + 2^B)^2 * S = dds + 2^(B+1) * d*S + 2^(2B) * S
					trial = TW'(p_s[k]) + (TW'(ds_s[k]) << (B + 1))
						+ (TW'(s_s[k]) << (2 * B));
					dnext = TW'(ds_s[k]) + (TW'(s_s[k]) << B);
					if (trial <= TW'(S_LIMIT)) begin
						nd = d_s[k] | (DEPTH_BITS'(1) << B);
						np = trial[S_BITS-1:0];
						nds = dnext[S_BITS-1:0];
					end else begin
						nd = d_s[k];
						np = p_s[k];
						nds = ds_s[k];
					end
				end
			end else begin : g_pass
				assign nd = d_s[k];
				assign np = p_s[k];
				assign nds = ds_s[k];
			end
			always_ff @(posedge clk) begin
				if (en[k]) begin
					d_s[k+1] <= nd;
					p_s[k+1] <= np;
					ds_s[k+1] <= nds;
					s_s[k+1] <= s_s[k];
					near_s[k+1] <= near_s[k];
				end
			end
		end
	endgenerate

	assign depth = near_s[NS] ? DEPTH_FULL : d_s[NS];

endmodule

### hw/rtl/ptps_cordic.sv
module ptps_cordic #(
	parameter int AW = 32,
	parameter int NS = 12,
	parameter int NITER = 12
) (
	input logic clk,
	input logic [NS-1:0] en,
	input logic signed [AW-1:0] x,
	input logic signed [AW-1:0] y,
	input logic signed [ptps_pkg::Z_BITS-1:0] z,
	input logic iter,
	output logic [ptps_pkg::ANGLE_BITS-1:0] angle
);
	import ptps_pkg::*;

	logic signed [AW-1:0] x_s [NS+1];
	logic signed [AW-1:0] y_s [NS+1];
	logic signed [Z_BITS-1:0] z_s [NS+1];
	logic iter_s [NS+1];

	assign x_s[0] = x;
	assign y_s[0] = y;
	assign z_s[0] = z;
	assign iter_s[0] = iter;

	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_stage
			logic signed [AW-1:0] nx, ny;
			logic signed [Z_BITS-1:0] nz;
			if (k < NITER) begin : g_rot
				logic signed [AW-1:0] xs, ys;
				assign xs = x_s[k] >>> k;
				assign ys = y_s[k] >>> k;
				always_comb begin
					nx = x_s[k];
					ny = y_s[k];
					nz = z_s[k];
					if (iter_s[k]) begin
						if (y_s[k] >= 0) begin
							nx = x_s[k] + ys;
							ny = y_s[k] - xs;
							nz = z_s[k] + atan_step(k);
						end else begin
							nx = x_s[k] - ys;
							ny = y_s[k] + xs;
							nz = z_s[k] - atan_step(k);
						end
					end
				end
			end else begin : g_pass
				assign nx = x_s[k];
				assign ny = y_s[k];
				assign nz = z_s[k];
			end
			always_ff @(posedge clk) begin
				if (en[k]) begin
					x_s[k+1] <= nx;
					y_s[k+1] <= ny;
					z_s[k+1] <= nz;
					iter_s[k+1] <= iter_s[k];
				end
			end
		end
	endgenerate

	logic [Z_BITS:0] z_off;

	// 256 + floor(phi / 4096)
	assign z_off = {z_s[NS][Z_BITS-1], z_s[NS]} + Z_OFFSET;
	assign angle = z_off[Z_BITS-1:Z_BITS-ANGLE_BITS];

endmodule

### hw/rtl/ptps_shade.sv
module ptps_shade (
	input logic clk,
	input logic en,
	input logic [ptps_pkg::DEPTH_BITS-1:0] depth,
	input logic [ptps_pkg::ANGLE_BITS-1:0] angle,
	input logic [ptps_pkg::TIME_BITS-1:0] t,
	input logic [ptps_pkg::THIRD_BITS-1:0] t_third,
	output logic [7:0] intensity_s
);
	import ptps_pkg::*;

	logic [TIME_BITS:0] dsum;
	logic [TIME_BITS-1:0] asum;
	logic on;
	logic [7:0] fade;
	logic [15:0] fprod;
	logic [7:0] dim;

	assign dsum = (TIME_BITS+1)'(depth) + (TIME_BITS+1)'(t);
	assign asum = TIME_BITS'(angle) + TIME_BITS'(t_third);
	assign on = dsum[4] ^ asum[4];
	assign fade = (depth > DEPTH_BITS'(255)) ? 8'd255 : depth[7:0];
	assign fprod = fade * FIFTH_MUL;
	assign dim = 8'(fprod >> FIFTH_SHIFT);

	always_ff @(posedge clk) begin
		if (en) begin
			intensity_s <= on ? fade : dim;
		end
	end

endmodule
